[sv/i2cmts_pkg.sv]
// Package: shared types, codes and sizes for the I2C master transaction sequencer.
package i2cmts_pkg;

	localparam int TX_DEPTH = 16;
	localparam int TX_AW    = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
	localparam logic [8:0] TX_DEPTH_V = 9'(TX_DEPTH);
	localparam logic [7:0] READ_FLAG  = 8'b0000_0001;

	typedef enum logic [1:0] {
		MODE_LOAD  = 2'd0,
		MODE_WRITE = 2'd1,
		MODE_READ  = 2'd2,
		MODE_EVENT = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ACT_NONE   = 3'd0,
		ACT_START  = 3'd1,
		ACT_WRITE  = 3'd2,
		ACT_RXEN   = 3'd3,
		ACT_ACKBIT = 3'd4,
		ACT_STOP   = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		ERR_NONE = 2'd0,
		ERR_ADDR = 2'd1,
		ERR_DATA = 2'd2
	} error_t;

	typedef enum logic [10:0] {
		PH_IDLE         = 11'b000_0000_0001,
		PH_W_ADDR       = 11'b000_0000_0010,
		PH_W_ADDR_ACK   = 11'b000_0000_0100,
		PH_W_DATA_ACK   = 11'b000_0000_1000,
		PH_W_STOP       = 11'b000_0001_0000,
		PH_R_ADDR       = 11'b000_0010_0000,
		PH_R_ADDR_ACK   = 11'b000_0100_0000,
		PH_R_RECV       = 11'b000_1000_0000,
		PH_R_AFTER_ACK  = 11'b001_0000_0000,
		PH_R_AFTER_NACK = 11'b010_0000_0000,
		PH_R_STOP       = 11'b100_0000_0000
	} phase_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [3:0] load_index;
		logic [7:0] data_byte;
		logic [4:0] length;
		logic [7:0] dev_address;
		logic       ack_status;
		logic [7:0] bus_rx_byte;
	} cmd_t;

	typedef struct packed {
		logic       accepted;
		logic [2:0] action;
		logic [7:0] bus_byte;
		logic       ack_bit;
		logic       rx_valid;
		logic [7:0] rx_data;
		logic       rx_last;
		logic       done_res;
		logic [1:0] error;
		logic       busy_res;
	} res_t;

	// Write port of the transmit byte store
	typedef struct packed {
		logic             we;
		logic [TX_AW-1:0] addr;
		logic [7:0]       data;
	} store_wr_t;

endpackage

[sv/i2cmts_txstore.sv]
// Transmit byte store: flop array, one write port, one read port.
module i2cmts_txstore (
	input  logic                          clk,
	input  i2cmts_pkg::store_wr_t         wr,
	input  logic [i2cmts_pkg::TX_AW-1:0]  raddr,
	output logic [7:0]                    rdata
);

	logic [7:0] mem_q [i2cmts_pkg::TX_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	assign rdata = mem_q[raddr];

endmodule

[sv/i2cmts_seq.sv]
// Sequencer: transaction phase registers and the per-transaction result logic.
module i2cmts_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  i2cmts_pkg::cmd_t              cmd,
	input  logic [7:0]                    store_rdata,
	output logic [i2cmts_pkg::TX_AW-1:0]  store_raddr,
	output i2cmts_pkg::store_wr_t         store_wr,
	output i2cmts_pkg::res_t              res
);

	i2cmts_pkg::phase_t phase_q, phase_d;
	logic [7:0] target_address_q, target_address_d;
	logic [4:0] send_count_q, send_count_d;
	logic [4:0] transfer_length_q, transfer_length_d;
	logic [4:0] rx_count_q, rx_count_d;

	logic [4:0] len_eff;
	logic [4:0] wr_len;
	logic [4:0] rx_count_inc;
	logic       send_in_store;
	logic [7:0] store_byte;

	assign len_eff = (cmd.length == 5'd0) ? 5'd1 : cmd.length;
	assign wr_len  = ({4'd0, len_eff} > i2cmts_pkg::TX_DEPTH_V) ?
		5'(i2cmts_pkg::TX_DEPTH) : len_eff;
	assign rx_count_inc = rx_count_q + 5'd1;

	// first data byte comes from slot zero, later ones from the send count
	assign store_raddr = (phase_q == i2cmts_pkg::PH_W_ADDR_ACK) ?
		'0 : i2cmts_pkg::TX_AW'(send_count_q);
	assign send_in_store = (phase_q == i2cmts_pkg::PH_W_ADDR_ACK) ||
		({4'd0, send_count_q} < i2cmts_pkg::TX_DEPTH_V);
	assign store_byte = send_in_store ? store_rdata : 8'd0;

	always_comb begin
		store_wr.we   = go && (cmd.mode == i2cmts_pkg::MODE_LOAD) &&
			({5'd0, cmd.load_index} < i2cmts_pkg::TX_DEPTH_V);
		store_wr.addr = i2cmts_pkg::TX_AW'(cmd.load_index);
		store_wr.data = cmd.data_byte;
	end

	always_comb begin
		phase_d           = phase_q;
		target_address_d  = target_address_q;
		send_count_d      = send_count_q;
		transfer_length_d = transfer_length_q;
		rx_count_d        = rx_count_q;
		res               = '0;

		case (cmd.mode)
			i2cmts_pkg::MODE_LOAD: begin
			end
			i2cmts_pkg::MODE_WRITE: begin
				if (phase_q == i2cmts_pkg::PH_IDLE) begin
					res.accepted      = 1'b1;
					res.action        = i2cmts_pkg::ACT_START;
					target_address_d  = cmd.dev_address;
					send_count_d      = 5'd0;
					transfer_length_d = wr_len;
					phase_d           = i2cmts_pkg::PH_W_ADDR;
				end
			end
			i2cmts_pkg::MODE_READ: begin
				if (phase_q == i2cmts_pkg::PH_IDLE) begin
					res.accepted      = 1'b1;
					res.action        = i2cmts_pkg::ACT_START;
					target_address_d  = cmd.dev_address | i2cmts_pkg::READ_FLAG;
					rx_count_d        = 5'd0;
					transfer_length_d = len_eff;
					phase_d           = i2cmts_pkg::PH_R_ADDR;
				end
			end
			default: begin
				case (phase_q)
					i2cmts_pkg::PH_IDLE: begin
					end
					i2cmts_pkg::PH_W_ADDR, i2cmts_pkg::PH_R_ADDR: begin
						res.action   = i2cmts_pkg::ACT_WRITE;
						res.bus_byte = target_address_q;
						phase_d = (phase_q == i2cmts_pkg::PH_W_ADDR) ?
							i2cmts_pkg::PH_W_ADDR_ACK : i2cmts_pkg::PH_R_ADDR_ACK;
					end
					i2cmts_pkg::PH_W_ADDR_ACK, i2cmts_pkg::PH_R_ADDR_ACK: begin
						if (cmd.ack_status) begin
							res.action = i2cmts_pkg::ACT_STOP;
							res.error  = i2cmts_pkg::ERR_ADDR;
							phase_d    = i2cmts_pkg::PH_IDLE;
						end else if (phase_q == i2cmts_pkg::PH_W_ADDR_ACK) begin
							res.action   = i2cmts_pkg::ACT_WRITE;
							res.bus_byte = store_byte;
							send_count_d = 5'd1;
							phase_d      = i2cmts_pkg::PH_W_DATA_ACK;
						end else begin
							res.action = i2cmts_pkg::ACT_RXEN;
							phase_d    = i2cmts_pkg::PH_R_RECV;
						end
					end
					i2cmts_pkg::PH_W_DATA_ACK: begin
						if (cmd.ack_status) begin
							res.action = i2cmts_pkg::ACT_STOP;
							res.error  = i2cmts_pkg::ERR_DATA;
							phase_d    = i2cmts_pkg::PH_IDLE;
						end else if (send_count_q >= transfer_length_q) begin
							res.action = i2cmts_pkg::ACT_STOP;
							phase_d    = i2cmts_pkg::PH_W_STOP;
						end else begin
							res.action   = i2cmts_pkg::ACT_WRITE;
							res.bus_byte = store_byte;
							send_count_d = send_count_q + 5'd1;
						end
					end
					i2cmts_pkg::PH_R_RECV: begin
						res.rx_valid = 1'b1;
						res.rx_data  = cmd.bus_rx_byte;
						res.action   = i2cmts_pkg::ACT_ACKBIT;
						rx_count_d   = rx_count_inc;
						// NACK on the last requested byte
						if (rx_count_inc >= transfer_length_q) begin
							res.rx_last = 1'b1;
							res.ack_bit = 1'b1;
							phase_d     = i2cmts_pkg::PH_R_AFTER_NACK;
						end else begin
							phase_d = i2cmts_pkg::PH_R_AFTER_ACK;
						end
					end
					i2cmts_pkg::PH_R_AFTER_ACK: begin
						res.action = i2cmts_pkg::ACT_RXEN;
						phase_d    = i2cmts_pkg::PH_R_RECV;
					end
					i2cmts_pkg::PH_R_AFTER_NACK: begin
						res.action = i2cmts_pkg::ACT_STOP;
						phase_d    = i2cmts_pkg::PH_R_STOP;
					end
					i2cmts_pkg::PH_W_STOP, i2cmts_pkg::PH_R_STOP: begin
						res.done_res = 1'b1;
						phase_d      = i2cmts_pkg::PH_IDLE;
					end
					default: begin
						phase_d = i2cmts_pkg::PH_IDLE;
					end
				endcase
			end
		endcase

		res.busy_res = (phase_d != i2cmts_pkg::PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q           <= i2cmts_pkg::PH_IDLE;
			target_address_q  <= 8'd0;
			send_count_q      <= 5'd0;
			transfer_length_q <= 5'd0;
			rx_count_q        <= 5'd0;
		end else if (go) begin
			phase_q           <= phase_d;
			target_address_q  <= target_address_d;
			send_count_q      <= send_count_d;
			transfer_length_q <= transfer_length_d;
			rx_count_q        <= rx_count_d;
		end
	end

endmodule

[sv/i2c_master_transaction_sequencer.sv]
// Top level: command input register, sequencer, transmit store and result register.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------------
//   command | cmd_valid/cmd_stall  | mode load_index data_byte length dev_address
//           |                      | ack_status bus_rx_byte
//   result  | res_valid/res_stall  | accepted action bus_byte ack_bit rx_valid rx_data
//           |                      | rx_last done_res error busy_res
//
// One transaction per cycle while the result channel is not stalled; a taken command is held
// in the input register, and the sequencer step moves its result into the result register.
// The command is stalled only while a result is held in the output register.
// Reset returns the sequencer to idle and empties both registers; the transmit
// store is not cleared.
module i2c_master_transaction_sequencer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_stall,
	input  logic [1:0] mode,
	input  logic [3:0] load_index,
	input  logic [7:0] data_byte,
	input  logic [4:0] length,
	input  logic [7:0] dev_address,
	input  logic       ack_status,
	input  logic [7:0] bus_rx_byte,
	output logic       res_valid,
	input  logic       res_stall,
	output logic       accepted,
	output logic [2:0] action,
	output logic [7:0] bus_byte,
	output logic       ack_bit,
	output logic       rx_valid,
	output logic [7:0] rx_data,
	output logic       rx_last,
	output logic       done_res,
	output logic [1:0] error,
	output logic       busy_res
);

	logic                 valid_s1;
	i2cmts_pkg::cmd_t     cmd_s1;
	logic                 res_valid_q;
	i2cmts_pkg::res_t     res_q;
	i2cmts_pkg::res_t     res_d;
	logic                 go;
	logic                 take;
	logic [i2cmts_pkg::TX_AW-1:0] store_raddr;
	logic [7:0]           store_rdata;
	i2cmts_pkg::store_wr_t store_wr;

	assign go        = valid_s1 && (!res_valid_q || !res_stall);
	assign cmd_stall = valid_s1 && !go;
	assign take      = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1.mode          <= mode;
			cmd_s1.load_index    <= load_index;
			cmd_s1.data_byte     <= data_byte;
			cmd_s1.length        <= length;
			cmd_s1.dev_address   <= dev_address;
			cmd_s1.ack_status    <= ack_status;
			cmd_s1.bus_rx_byte   <= bus_rx_byte;
		end
	end

	i2cmts_txstore u_store (
		.clk   (clk),
		.wr    (store_wr),
		.raddr (store_raddr),
		.rdata (store_rdata)
	);

	i2cmts_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.go          (go),
		.cmd         (cmd_s1),
		.store_rdata (store_rdata),
		.store_raddr (store_raddr),
		.store_wr    (store_wr),
		.res         (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (go) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign accepted  = res_q.accepted;
	assign action    = res_q.action;
	assign bus_byte  = res_q.bus_byte;
	assign ack_bit   = res_q.ack_bit;
	assign rx_valid  = res_q.rx_valid;
	assign rx_data   = res_q.rx_data;
	assign rx_last   = res_q.rx_last;
	assign done_res  = res_q.done_res;
	assign error     = res_q.error;
	assign busy_res  = res_q.busy_res;

	a_err_stops: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (error != i2cmts_pkg::ERR_NONE)
		|-> (action == i2cmts_pkg::ACT_STOP) && !busy_res && !done_res)
		else $error("error result without stop or still busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && done_res |-> !busy_res && (action == i2cmts_pkg::ACT_NONE))
		else $error("done result while still busy");

	a_rx_ack: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && rx_valid
		|-> (action == i2cmts_pkg::ACT_ACKBIT) && (ack_bit == rx_last) && busy_res)
		else $error("received byte with wrong acknowledge");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && accepted |-> (action == i2cmts_pkg::ACT_START) && busy_res)
		else $error("accepted start without start action");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_q))
		else $error("held result changed under stall");

endmodule

[test/i2c_master_transaction_sequencer_tb.sv]
// Testbench: I2C master transaction sequencer, checked against a built-in predictor.
`timescale 1ns / 100ps

module i2c_master_transaction_sequencer_tb;

	localparam int CYCLE_LIMIT = 300000;
	localparam int RANDOM_ITEMS = 620;
	localparam int QUIET_ITEMS = 80;

	logic       clk;
	logic       arst_n;
	logic       cmd_valid;
	logic       cmd_stall;
	logic [1:0] mode;
	logic [3:0] load_index;
	logic [7:0] data_byte;
	logic [4:0] length;
	logic [7:0] dev_address;
	logic       ack_status;
	logic [7:0] bus_rx_byte;
	logic       res_valid;
	logic       res_stall;
	logic       accepted;
	logic [2:0] action;
	logic [7:0] bus_byte;
	logic       ack_bit;
	logic       rx_valid;
	logic [7:0] rx_data;
	logic       rx_last;
	logic       done_res;
	logic [1:0] error;
	logic       busy_res;

	i2c_master_transaction_sequencer DUT (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
		.mode(mode), .load_index(load_index), .data_byte(data_byte), .length(length),
		.dev_address(dev_address), .ack_status(ack_status), .bus_rx_byte(bus_rx_byte),
		.res_valid(res_valid), .res_stall(res_stall),
		.accepted(accepted), .action(action), .bus_byte(bus_byte), .ack_bit(ack_bit),
		.rx_valid(rx_valid), .rx_data(rx_data), .rx_last(rx_last),
		.done_res(done_res), .error(error), .busy_res(busy_res)
	);

	// predicted sequencer state
	i2cmts_pkg::phase_t seq_phase;
	logic [7:0] tgt_addr;
	logic [7:0] tx_bytes [i2cmts_pkg::TX_DEPTH];
	logic [4:0] sent_cnt;
	logic [4:0] xfer_len;
	logic [4:0] got_cnt;

	i2cmts_pkg::res_t answer_q[$];
	int   fail_cnt;
	int   items_sent;
	int   cycle_cnt;
	bit   gaps_on;
	bit   stalls_on;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic i2cmts_pkg::res_t step_sequencer(input i2cmts_pkg::cmd_t c);
		i2cmts_pkg::res_t r;
		logic [4:0]       len;
		r = '0;
		len = (c.length == 5'd0) ? 5'd1 : c.length;
		case (i2cmts_pkg::mode_t'(c.mode))
			i2cmts_pkg::MODE_LOAD: begin
				tx_bytes[c.load_index] = c.data_byte;
			end
			i2cmts_pkg::MODE_WRITE, i2cmts_pkg::MODE_READ: begin
				if (seq_phase == i2cmts_pkg::PH_IDLE) begin
					r.accepted = 1'b1;
					r.action = i2cmts_pkg::ACT_START;
					if (c.mode == i2cmts_pkg::MODE_WRITE) begin
						if (len > i2cmts_pkg::TX_DEPTH)
							len = 5'(i2cmts_pkg::TX_DEPTH);
						tgt_addr = c.dev_address;
						sent_cnt = '0;
						seq_phase = i2cmts_pkg::PH_W_ADDR;
					end else begin
						tgt_addr = c.dev_address | i2cmts_pkg::READ_FLAG;
						got_cnt = '0;
						seq_phase = i2cmts_pkg::PH_R_ADDR;
					end
					xfer_len = len;
				end
			end
			default: begin
				case (seq_phase)
					i2cmts_pkg::PH_W_ADDR, i2cmts_pkg::PH_R_ADDR: begin
						r.action = i2cmts_pkg::ACT_WRITE;
						r.bus_byte = tgt_addr;
						seq_phase = (seq_phase == i2cmts_pkg::PH_W_ADDR) ?
							i2cmts_pkg::PH_W_ADDR_ACK : i2cmts_pkg::PH_R_ADDR_ACK;
					end
					i2cmts_pkg::PH_W_ADDR_ACK, i2cmts_pkg::PH_R_ADDR_ACK: begin
						if (c.ack_status) begin
							r.action = i2cmts_pkg::ACT_STOP;
							r.error = i2cmts_pkg::ERR_ADDR;
							seq_phase = i2cmts_pkg::PH_IDLE;
						end else if (seq_phase == i2cmts_pkg::PH_W_ADDR_ACK) begin
							r.action = i2cmts_pkg::ACT_WRITE;
							r.bus_byte = tx_bytes[0];
							sent_cnt = 5'd1;
							seq_phase = i2cmts_pkg::PH_W_DATA_ACK;
						end else begin
							r.action = i2cmts_pkg::ACT_RXEN;
							seq_phase = i2cmts_pkg::PH_R_RECV;
						end
					end
					i2cmts_pkg::PH_W_DATA_ACK: begin
						if (c.ack_status) begin
							r.action = i2cmts_pkg::ACT_STOP;
							r.error = i2cmts_pkg::ERR_DATA;
							seq_phase = i2cmts_pkg::PH_IDLE;
						end else if (sent_cnt >= xfer_len) begin
							r.action = i2cmts_pkg::ACT_STOP;
							seq_phase = i2cmts_pkg::PH_W_STOP;
						end else begin
							r.action = i2cmts_pkg::ACT_WRITE;
							r.bus_byte = tx_bytes[sent_cnt[3:0]];
							sent_cnt = sent_cnt + 5'd1;
						end
					end
					i2cmts_pkg::PH_R_RECV: begin
						r.rx_valid = 1'b1;
						r.rx_data = c.bus_rx_byte;
						r.action = i2cmts_pkg::ACT_ACKBIT;
						got_cnt = got_cnt + 5'd1;
						if (got_cnt >= xfer_len) begin
							r.rx_last = 1'b1;
							r.ack_bit = 1'b1;
							seq_phase = i2cmts_pkg::PH_R_AFTER_NACK;
						end else begin
							seq_phase = i2cmts_pkg::PH_R_AFTER_ACK;
						end
					end
					i2cmts_pkg::PH_R_AFTER_ACK: begin
						r.action = i2cmts_pkg::ACT_RXEN;
						seq_phase = i2cmts_pkg::PH_R_RECV;
					end
					i2cmts_pkg::PH_R_AFTER_NACK: begin
						r.action = i2cmts_pkg::ACT_STOP;
						seq_phase = i2cmts_pkg::PH_R_STOP;
					end
					i2cmts_pkg::PH_W_STOP, i2cmts_pkg::PH_R_STOP: begin
						r.done_res = 1'b1;
						seq_phase = i2cmts_pkg::PH_IDLE;
					end
					default: seq_phase = i2cmts_pkg::PH_IDLE;
				endcase
			end
		endcase
		r.busy_res = (seq_phase != i2cmts_pkg::PH_IDLE);
		return r;
	endfunction

	function automatic i2cmts_pkg::cmd_t rand_cmd();
		logic [63:0]      raw;
		i2cmts_pkg::cmd_t c;
		raw = {$urandom, $urandom};
		c = raw[35:0];
		return c;
	endfunction

	task automatic note_failure(input string msg);
		if (fail_cnt < 10)
			$display("%s", msg);
		fail_cnt++;
	endtask

	// one transaction on the command channel; prediction made at the accepting edge
	task automatic send_cmd(input i2cmts_pkg::cmd_t c);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		mode <= c.mode;
		load_index <= c.load_index;
		data_byte <= c.data_byte;
		length <= c.length;
		dev_address <= c.dev_address;
		ack_status <= c.ack_status;
		bus_rx_byte <= c.bus_rx_byte;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		answer_q.push_back(step_sequencer(c));
		items_sent++;
	endtask

	task automatic drain_answers();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (answer_q.size() != 0);
	endtask

	task automatic send_event(input logic nack, input logic [7:0] rx_byte);
		i2cmts_pkg::cmd_t c;
		c = rand_cmd();
		c.mode = i2cmts_pkg::MODE_EVENT;
		c.ack_status = nack;
		c.bus_rx_byte = rx_byte;
		send_cmd(c);
	endtask

	task automatic send_start(input i2cmts_pkg::mode_t m, input logic [4:0] len,
		input logic [7:0] addr);
		i2cmts_pkg::cmd_t c;
		c = rand_cmd();
		c.mode = m;
		c.length = len;
		c.dev_address = addr;
		send_cmd(c);
	endtask

	// every slot written once so no transaction ever reads an unloaded byte
	task automatic test_store_preload();
		i2cmts_pkg::cmd_t c;
		for (int i = 0; i < i2cmts_pkg::TX_DEPTH; i++) begin
			c = rand_cmd();
			c.mode = i2cmts_pkg::MODE_LOAD;
			c.load_index = 4'(i);
			c.data_byte = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom);
			send_cmd(c);
		end
	endtask

	task automatic test_directed();
		i2cmts_pkg::cmd_t c;
		// zero length write to an all-ones address, refused start and load mid-transaction
		send_start(i2cmts_pkg::MODE_WRITE, 5'd0, 8'hFF);
		send_event(1'b0, 8'h00);
		send_start(i2cmts_pkg::MODE_READ, 5'd3, 8'h10);
		c = rand_cmd();
		c.mode = i2cmts_pkg::MODE_LOAD;
		c.load_index = 4'd0;
		c.data_byte = 8'hA5;
		send_cmd(c);
		send_event(1'b0, 8'hFF);
		send_event(1'b0, 8'h00);
		send_event(1'b0, 8'h00);
		// event while idle
		send_event(1'b1, 8'hFF);
		// single byte read, address with bit 0 clear
		send_start(i2cmts_pkg::MODE_READ, 5'd1, 8'h00);
		send_event(1'b0, 8'h00);
		send_event(1'b0, 8'h00);
		send_event(1'b0, 8'hFF);
		send_event(1'b0, 8'h00);
		send_event(1'b0, 8'h00);
		// address not acknowledged, then the stop completion lands on idle
		send_start(i2cmts_pkg::MODE_WRITE, 5'd2, 8'h5A);
		send_event(1'b0, 8'h00);
		send_event(1'b1, 8'h00);
		send_event(1'b0, 8'h00);
		// longest write saturates at the store size; data not acknowledged
		send_start(i2cmts_pkg::MODE_WRITE, 5'd31, 8'h80);
		send_event(1'b0, 8'h00);
		send_event(1'b0, 8'h00);
		send_event(1'b1, 8'h00);
	endtask

	// noise, then a start, then events until the sequencer is idle again
	task automatic run_sequence();
		i2cmts_pkg::cmd_t c;
		if ($urandom_range(0, 4) == 0)
			send_cmd(rand_cmd());
		if (seq_phase == i2cmts_pkg::PH_IDLE) begin
			c = rand_cmd();
			c.mode = $urandom_range(0, 1) ? i2cmts_pkg::MODE_WRITE : i2cmts_pkg::MODE_READ;
			c.length = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
				: 5'($urandom_range(0, 5));
			send_cmd(c);
		end
		while (seq_phase != i2cmts_pkg::PH_IDLE) begin
			c = rand_cmd();
			case ($urandom_range(0, 19))
				0: c.mode = i2cmts_pkg::MODE_LOAD;
				1: c.mode = $urandom_range(0, 1) ? i2cmts_pkg::MODE_WRITE
					: i2cmts_pkg::MODE_READ;
				default: begin
					c.mode = i2cmts_pkg::MODE_EVENT;
					c.ack_status = ($urandom_range(0, 24) == 0);
				end
			endcase
			send_cmd(c);
		end
	endtask

	task automatic test_random_traffic(input int n_items);
		int stop_at;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			stalls_on = ($urandom_range(0, 3) != 0);
			run_sequence();
		end
	endtask

	task automatic test_idle_pause();
		drain_answers();
	endtask

	task automatic test_quiet_tail();
		int stop_at;
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		stop_at = items_sent + QUIET_ITEMS;
		while (items_sent < stop_at)
			run_sequence();
	endtask

	// result channel stall in random bursts
	initial begin
		int burst;
		burst = 0;
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (burst != 0) begin
				res_stall <= 1'b1;
				burst--;
			end else if (stalls_on && $urandom_range(0, 7) == 0) begin
				res_stall <= 1'b1;
				burst = $urandom_range(1, 13) - 1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	// result checker
	initial begin
		i2cmts_pkg::res_t got;
		i2cmts_pkg::res_t want;
		forever begin
			@(posedge clk);
			if (arst_n && res_valid && !res_stall) begin
				got = {accepted, action, bus_byte, ack_bit, rx_valid, rx_data, rx_last,
					done_res, error, busy_res};
				if (answer_q.size() == 0) begin
					note_failure($sformatf("unexpected transaction at cycle %0d", cycle_cnt));
				end else begin
					want = answer_q.pop_front();
					if (got !== want)
						note_failure($sformatf({"mismatch at cycle %0d: exp acc=%0d act=%0d ",
							"byte=%h ack=%0d rxv=%0d rxd=%h last=%0d done=%0d err=%0d ",
							"busy=%0d | got acc=%0d act=%0d byte=%h ack=%0d rxv=%0d ",
							"rxd=%h last=%0d done=%0d err=%0d busy=%0d"}, cycle_cnt,
							want.accepted, want.action, want.bus_byte, want.ack_bit,
							want.rx_valid, want.rx_data, want.rx_last, want.done_res,
							want.error, want.busy_res, got.accepted, got.action,
							got.bus_byte, got.ack_bit, got.rx_valid, got.rx_data,
							got.rx_last, got.done_res, got.error, got.busy_res));
				end
			end
		end
	end

	// watchdog
	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		fail_cnt = 0;
		items_sent = 0;
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		seq_phase = i2cmts_pkg::PH_IDLE;
		tgt_addr = '0;
		sent_cnt = '0;
		xfer_len = '0;
		got_cnt = '0;
		arst_n <= 1'b0;
		cmd_valid <= 1'b0;
		mode <= i2cmts_pkg::MODE_LOAD;
		load_index <= '0;
		data_byte <= '0;
		length <= '0;
		dev_address <= '0;
		ack_status <= 1'b0;
		bus_rx_byte <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_store_preload();
		test_directed();
		test_random_traffic(RANDOM_ITEMS / 2);
		test_idle_pause();
		test_random_traffic(RANDOM_ITEMS / 2);
		test_quiet_tail();

		drain_answers();
		repeat (8) @(posedge clk);
		if (fail_cnt == 0 && answer_q.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[files.f]
sv/i2cmts_pkg.sv
sv/i2cmts_txstore.sv
sv/i2cmts_seq.sv
sv/i2c_master_transaction_sequencer.sv
test/i2c_master_transaction_sequencer_tb.sv
